### design/ieval_pkg.sv
// Shared constants, operator codes and the precedence table of the
// infix evaluator. No dependencies.
`timescale 1ns / 1ps

package ieval_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   // operator codes as held on the operator stack
   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_MUL  = 3'd2;
   localparam logic [2:0] OP_DIV  = 3'd3;
   localparam logic [2:0] OP_LPAR = 3'd4;
   localparam logic [2:0] OP_RPAR = 3'd5;
   localparam logic [2:0] OP_END  = 3'd6;
   localparam logic [2:0] OP_MARK = 3'd6;
   localparam logic [2:0] OP_NONE = 3'd7;

   // precedence relations
   localparam logic [1:0] PR_LT  = 2'd0;
   localparam logic [1:0] PR_EQ  = 2'd1;
   localparam logic [1:0] PR_GT  = 2'd2;
   localparam logic [1:0] PR_ERR = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DIV0  = 2'd1;
   localparam logic [1:0] ST_OVFL  = 2'd2;
   localparam logic [1:0] ST_BADEX = 2'd3;

   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   // map a character to its operator code, OP_NONE for anything else
   function automatic logic [2:0] char_code(input logic [7:0] c);
      logic [2:0] r;
      case (c)
         8'h2B:   r = OP_ADD;
         8'h2D:   r = OP_SUB;
         8'h2A:   r = OP_MUL;
         8'h2F:   r = OP_DIV;
         8'h28:   r = OP_LPAR;
         8'h29:   r = OP_RPAR;
         8'h3D:   r = OP_END;
         default: r = OP_NONE;
      endcase
      return r;
   endfunction

   // relation between the stack top and an incoming operator
   function automatic logic [1:0] prec(input logic [2:0] top, input logic [2:0] code);
      logic [1:0] r;
      r = PR_ERR;
      case (top)
         OP_ADD, OP_SUB: begin
            r = (code == OP_MUL || code == OP_DIV || code == OP_LPAR) ? PR_LT : PR_GT;
         end
         OP_MUL, OP_DIV: begin
            r = (code == OP_LPAR) ? PR_LT : PR_GT;
         end
         OP_LPAR: begin
            if (code == OP_RPAR)     r = PR_EQ;
            else if (code == OP_END) r = PR_ERR;
            else                     r = PR_LT;
         end
         OP_RPAR: begin
            r = (code == OP_RPAR) ? PR_ERR : PR_GT;
         end
         default: begin
            // start marker and anything above it
            r = (code == OP_RPAR) ? PR_ERR : PR_LT;
         end
      endcase
      return r;
   endfunction

endpackage

### design/ieval_if.sv
// Valid/ready channel interfaces for characters in and results out.
// Depends on ieval_pkg.
`timescale 1ns / 1ps

interface ieval_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

interface ieval_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ieval_pkg::VALUE_WIDTH-1:0] value;
   logic [1:0]                             status;
   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

### design/ieval_div.sv
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on ieval_pkg.
`timescale 1ns / 1ps

module ieval_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  ieval_pkg::value_type  dividend,
   input  ieval_pkg::value_type  divisor,
   output logic                  done,
   output ieval_pkg::value_type  quotient
);

   localparam int W = ieval_pkg::VALUE_WIDTH;
   localparam int SW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          neg_ff, neg_in;
   logic [SW-1:0] step_ff, step_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [W:0]    shifted;
   logic [W:0]    diff;

   // one restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[W-1] ^ divisor[W-1];
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend[W-1] ? (~dividend + 1'b1) : dividend;
         dvs_in  = divisor[W-1] ? (~divisor + 1'b1) : divisor;
      end else if (busy_ff) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == SW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

### design/infix_expression_evaluator.sv
// Infix evaluator: a digit is taken in the idle state; an operator passes through
// S_NUM and S_CMP, and each reduction through S_RD and S_EXEC (a division also waits
// in S_DIV for the bit-serial divider); a matched parenthesis pair passes S_RD and S_EXEC.
// '=' adds the reductions, then the result waits in a response state until taken.
// One character at a time; throughput follows the reductions each operator causes.
// Synchronous reset empties both stacks (start marker on the operator stack).
// Depends on ieval_pkg, ieval_if and ieval_div.
`timescale 1ns / 1ps

module infix_expression_evaluator (
   input  logic        clock,
   input  logic        reset,
   ieval_req_if.sink   req_chan,
   ieval_rsp_if.source rsp_chan
);

   localparam int W = ieval_pkg::VALUE_WIDTH;
   localparam int D = ieval_pkg::STACK_DEPTH;
   localparam int CW = ieval_pkg::CNT_W;
   localparam int IW = ieval_pkg::IDX_W;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_NUM  = 7'b0000010,
      S_CMP  = 7'b0000100,
      S_RD   = 7'b0001000,
      S_EXEC = 7'b0010000,
      S_DIV  = 7'b0100000,
      S_RSP  = 7'b1000000
   } state_type;

   state_type       state_ff, state_in;
   logic [2:0]      code_ff, code_in;
   logic            eq_ff, eq_in;
   logic [CW-1:0]   op_cnt_ff, op_cnt_in;
   logic [2:0]      op_top_ff, op_top_in;
   logic [CW-1:0]   nd_cnt_ff, nd_cnt_in;
   logic [W-1:0]    nd_top_ff, nd_top_in;
   logic [W-1:0]    acc_ff, acc_in;
   logic            pend_ff, pend_in;
   logic [1:0]      err_ff, err_in;

   // stacks held in memories, read data registered
   logic [2:0]      op_mem [D];
   logic [W-1:0]    nd_mem [D];
   logic [2:0]      op_rdata_ff;
   logic [W-1:0]    nd_rdata_ff;
   logic [CW-1:0]   op_raddr;
   logic [CW-1:0]   nd_raddr;
   logic            op_we;
   logic [IW-1:0]   op_waddr;
   logic [2:0]      op_wdata;
   logic            nd_we;
   logic [IW-1:0]   nd_waddr;
   logic [W-1:0]    nd_wdata;

   logic            div_start;
   logic            div_done;
   logic [W-1:0]    div_q;

   logic [2:0]      in_code;
   logic            in_digit;
   logic [2:0]      next_op_top;
   logic [W-1:0]    alu_res;
   logic            is_end;

   assign op_raddr = op_cnt_ff - CW'(2);
   assign nd_raddr = nd_cnt_ff - CW'(2);

   always_ff @(posedge clock) begin
      if (op_we) op_mem[op_waddr] <= op_wdata;
      if (nd_we) nd_mem[nd_waddr] <= nd_wdata;
      op_rdata_ff <= op_mem[op_raddr[IW-1:0]];
      nd_rdata_ff <= nd_mem[nd_raddr[IW-1:0]];
   end

   ieval_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (nd_rdata_ff),
      .divisor  (nd_top_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign in_code  = ieval_pkg::char_code(req_chan.ch);
   assign in_digit = (req_chan.ch >= ieval_pkg::CH_ZERO) && (req_chan.ch <= ieval_pkg::CH_NINE);
   assign is_end   = (code_ff == ieval_pkg::OP_END);
   // entry under the top; the bottom entry is always the start marker
   assign next_op_top = (op_cnt_ff == CW'(2)) ? ieval_pkg::OP_MARK : op_rdata_ff;

   // arithmetic of one reduction: b op a, b from memory, a the cached top
   always_comb begin
      case (op_top_ff)
         ieval_pkg::OP_ADD: alu_res = nd_rdata_ff + nd_top_ff;
         ieval_pkg::OP_SUB: alu_res = nd_rdata_ff - nd_top_ff;
         default:           alu_res = W'(nd_rdata_ff * nd_top_ff);
      endcase
   end

   // control sequencer
   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      eq_in     = eq_ff;
      op_cnt_in = op_cnt_ff;
      op_top_in = op_top_ff;
      nd_cnt_in = nd_cnt_ff;
      nd_top_in = nd_top_ff;
      acc_in    = acc_ff;
      pend_in   = pend_ff;
      err_in    = err_ff;
      op_we     = 1'b0;
      op_waddr  = op_cnt_ff[IW-1:0];
      op_wdata  = code_ff;
      nd_we     = 1'b0;
      nd_waddr  = nd_cnt_ff[IW-1:0];
      nd_wdata  = acc_ff;
      div_start = 1'b0;
      req_chan.ready = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               code_in = in_code;
               if (in_digit) begin
                  if (err_ff == ieval_pkg::ST_OK) begin
                     acc_in  = (acc_ff << 3) + (acc_ff << 1)
                             + W'(req_chan.ch - ieval_pkg::CH_ZERO);
                     pend_in = 1'b1;
                  end
               end else if (in_code == ieval_pkg::OP_NONE) begin
                  if (err_ff == ieval_pkg::ST_OK) err_in = ieval_pkg::ST_BADEX;
               end else if (err_ff != ieval_pkg::ST_OK) begin
                  if (in_code == ieval_pkg::OP_END) state_in = S_RSP;
               end else begin
                  state_in = S_NUM;
               end
            end
         end

         // push a pending number
         S_NUM: begin
            if (pend_ff) begin
               if (nd_cnt_ff >= CW'(D)) begin
                  err_in = ieval_pkg::ST_OVFL;
               end else begin
                  nd_we     = 1'b1;
                  nd_top_in = acc_ff;
                  nd_cnt_in = nd_cnt_ff + 1'b1;
               end
            end
            acc_in   = '0;
            pend_in  = 1'b0;
            state_in = S_CMP;
         end

         // compare the incoming operator with the stack top
         S_CMP: begin
            eq_in = 1'b0;
            if (err_ff != ieval_pkg::ST_OK) begin
               state_in = is_end ? S_RSP : S_IDLE;
            end else if (op_top_ff == ieval_pkg::OP_MARK && is_end) begin
               if (nd_cnt_ff != CW'(1)) err_in = ieval_pkg::ST_BADEX;
               state_in = S_RSP;
            end else begin
               case (ieval_pkg::prec(op_top_ff, code_ff))
                  ieval_pkg::PR_LT: begin
                     if (op_cnt_ff >= CW'(D)) begin
                        err_in = ieval_pkg::ST_OVFL;
                     end else begin
                        op_we     = 1'b1;
                        op_top_in = code_ff;
                        op_cnt_in = op_cnt_ff + 1'b1;
                     end
                     state_in = is_end ? S_RSP : S_IDLE;
                  end
                  ieval_pkg::PR_EQ: begin
                     eq_in    = 1'b1;
                     state_in = S_RD;
                  end
                  ieval_pkg::PR_GT: begin
                     state_in = S_RD;
                  end
                  default: begin
                     err_in   = ieval_pkg::ST_BADEX;
                     state_in = is_end ? S_RSP : S_IDLE;
                  end
               endcase
            end
         end

         // memory read of the entries under both tops
         S_RD: begin
            state_in = S_EXEC;
         end

         S_EXEC: begin
            if (eq_ff) begin
               // parenthesis pair matched
               op_cnt_in = op_cnt_ff - 1'b1;
               op_top_in = next_op_top;
               state_in  = is_end ? S_RSP : S_IDLE;
            end else if (nd_cnt_ff < CW'(2) || op_cnt_ff < CW'(2)) begin
               err_in   = ieval_pkg::ST_BADEX;
               state_in = is_end ? S_RSP : S_IDLE;
            end else if (op_top_ff == ieval_pkg::OP_DIV) begin
               if (nd_top_ff == '0) begin
                  err_in   = ieval_pkg::ST_DIV0;
                  state_in = is_end ? S_RSP : S_IDLE;
               end else begin
                  div_start = 1'b1;
                  op_cnt_in = op_cnt_ff - 1'b1;
                  op_top_in = next_op_top;
                  nd_cnt_in = nd_cnt_ff - 1'b1;
                  state_in  = S_DIV;
               end
            end else if (op_top_ff == ieval_pkg::OP_ADD || op_top_ff == ieval_pkg::OP_SUB
                         || op_top_ff == ieval_pkg::OP_MUL) begin
               op_cnt_in = op_cnt_ff - 1'b1;
               op_top_in = next_op_top;
               nd_cnt_in = nd_cnt_ff - 1'b1;
               nd_we     = 1'b1;
               nd_waddr  = nd_raddr[IW-1:0];
               nd_wdata  = alu_res;
               nd_top_in = alu_res;
               state_in  = S_CMP;
            end else begin
               err_in   = ieval_pkg::ST_BADEX;
               state_in = is_end ? S_RSP : S_IDLE;
            end
         end

         S_DIV: begin
            if (div_done) begin
               nd_we     = 1'b1;
               nd_waddr  = nd_raddr[IW-1:0] + 1'b1;
               nd_wdata  = div_q;
               nd_top_in = div_q;
               state_in  = S_CMP;
            end
         end

         // hold the result item, then clear for the next expression
         S_RSP: begin
            if (rsp_chan.ready) begin
               op_cnt_in = CW'(1);
               op_top_in = ieval_pkg::OP_MARK;
               nd_cnt_in = '0;
               acc_in    = '0;
               pend_in   = 1'b0;
               err_in    = ieval_pkg::ST_OK;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid  = (state_ff == S_RSP);
   assign rsp_chan.value  = (err_ff == ieval_pkg::ST_OK) ? nd_top_ff : '0;
   assign rsp_chan.status = err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         op_cnt_ff <= CW'(1);
         op_top_ff <= ieval_pkg::OP_MARK;
         nd_cnt_ff <= '0;
         acc_ff    <= '0;
         pend_ff   <= 1'b0;
         err_ff    <= ieval_pkg::ST_OK;
         eq_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         op_cnt_ff <= op_cnt_in;
         op_top_ff <= op_top_in;
         nd_cnt_ff <= nd_cnt_in;
         acc_ff    <= acc_in;
         pend_ff   <= pend_in;
         err_ff    <= err_in;
         eq_ff     <= eq_in;
      end
      code_ff   <= code_in;
      nd_top_ff <= nd_top_in;
   end

endmodule

### test/infix_expression_evaluator_test.sv
// Self-checking test of the infix expression evaluator: character stream in,
// value and status out, checked against a predictor kept in this module.
// Depends on ieval_pkg, ieval_if and the evaluator RTL.
`timescale 1ns / 1ps

module infix_expression_evaluator_test;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int VW = ieval_pkg::VALUE_WIDTH;
   localparam int SD = ieval_pkg::STACK_DEPTH;

   typedef struct {
      logic signed [VW-1:0] value;
      logic [1:0]           status;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ieval_req_if req_chan ();
   ieval_rsp_if rsp_chan ();

   infix_expression_evaluator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #2 clock = ~clock;

   // predictor state
   logic [2:0]    op_stack [SD];
   int            op_count;
   logic [VW-1:0] num_stack [SD];
   int            num_count;
   logic [VW-1:0] accum;
   bit            accum_live;
   logic [1:0]    err;

   logic [7:0]  char_queue [$];
   outcome_type expected_results [$];
   int          failures = 0;
   bit          stimulus_done = 0;
   int          idle_cycles = 0;

   function automatic void clear_evaluator();
      foreach (op_stack[i]) op_stack[i] = ieval_pkg::OP_ADD;
      op_stack[0] = ieval_pkg::OP_MARK;
      op_count    = 1;
      num_count   = 0;
      accum       = '0;
      accum_live  = 0;
      err         = ieval_pkg::ST_OK;
   endfunction

   function automatic void flag(logic [1:0] e);
      if (err == ieval_pkg::ST_OK) err = e;
   endfunction

   function automatic void push_value(logic [VW-1:0] v);
      if (num_count >= SD) flag(ieval_pkg::ST_OVFL);
      else num_stack[num_count++] = v;
   endfunction

   // truncating signed division on magnitudes; min / -1 wraps
   function automatic logic [VW-1:0] quotient(logic [VW-1:0] b, logic [VW-1:0] a);
      logic [VW-1:0] mb, ma, q;
      mb = b[VW-1] ? -b : b;
      ma = a[VW-1] ? -a : a;
      q  = mb / ma;
      if (b[VW-1] != a[VW-1]) q = -q;
      return q;
   endfunction

   function automatic void reduce_top();
      logic [VW-1:0] a, b, r;
      logic [2:0]    op;
      if (num_count < 2 || op_count < 2) begin
         flag(ieval_pkg::ST_BADEX);
         return;
      end
      a  = num_stack[--num_count];
      b  = num_stack[--num_count];
      op = op_stack[--op_count];
      case (op)
         ieval_pkg::OP_ADD: r = b + a;
         ieval_pkg::OP_SUB: r = b - a;
         ieval_pkg::OP_MUL: r = b * a;
         ieval_pkg::OP_DIV: begin
            if (a == '0) begin
               flag(ieval_pkg::ST_DIV0);
               return;
            end
            r = quotient(b, a);
         end
         default: begin
            flag(ieval_pkg::ST_BADEX);
            return;
         end
      endcase
      push_value(r);
   endfunction

   // own precedence relation: stack top against incoming operator
   function automatic logic [1:0] relation(logic [2:0] top, logic [2:0] code);
      case (top)
         ieval_pkg::OP_ADD, ieval_pkg::OP_SUB:
            return (code == ieval_pkg::OP_MUL || code == ieval_pkg::OP_DIV ||
                    code == ieval_pkg::OP_LPAR) ? ieval_pkg::PR_LT : ieval_pkg::PR_GT;
         ieval_pkg::OP_MUL, ieval_pkg::OP_DIV:
            return (code == ieval_pkg::OP_LPAR) ? ieval_pkg::PR_LT : ieval_pkg::PR_GT;
         ieval_pkg::OP_LPAR: begin
            if (code == ieval_pkg::OP_RPAR) return ieval_pkg::PR_EQ;
            if (code == ieval_pkg::OP_END)  return ieval_pkg::PR_ERR;
            return ieval_pkg::PR_LT;
         end
         ieval_pkg::OP_RPAR:
            return (code == ieval_pkg::OP_RPAR) ? ieval_pkg::PR_ERR : ieval_pkg::PR_GT;
         default:
            return (code == ieval_pkg::OP_RPAR) ? ieval_pkg::PR_ERR : ieval_pkg::PR_LT;
      endcase
   endfunction

   function automatic void apply_operator(logic [2:0] code);
      logic [2:0] top;
      logic [1:0] rel;
      if (accum_live) begin
         push_value(accum);
         accum      = '0;
         accum_live = 0;
      end
      for (int g = 0; g <= SD && err == ieval_pkg::ST_OK; g++) begin
         if (op_count == 0) begin
            flag(ieval_pkg::ST_BADEX);
            return;
         end
         top = op_stack[op_count-1];
         if (top == ieval_pkg::OP_MARK && code == ieval_pkg::OP_END) begin
            if (num_count != 1) flag(ieval_pkg::ST_BADEX);
            return;
         end
         rel = relation(top, code);
         if (rel == ieval_pkg::PR_LT) begin
            if (op_count >= SD) flag(ieval_pkg::ST_OVFL);
            else op_stack[op_count++] = code;
            return;
         end else if (rel == ieval_pkg::PR_EQ) begin
            op_count--;
            return;
         end else if (rel == ieval_pkg::PR_GT) begin
            reduce_top();
         end else begin
            flag(ieval_pkg::ST_BADEX);
            return;
         end
      end
   endfunction

   // one accepted character; queues a result on '='
   function automatic void predict_char(logic [7:0] c);
      logic [2:0]  code;
      outcome_type o;
      code = ieval_pkg::OP_NONE;
      case (c)
         "+": code = ieval_pkg::OP_ADD;
         "-": code = ieval_pkg::OP_SUB;
         "*": code = ieval_pkg::OP_MUL;
         "/": code = ieval_pkg::OP_DIV;
         "(": code = ieval_pkg::OP_LPAR;
         ")": code = ieval_pkg::OP_RPAR;
         "=": code = ieval_pkg::OP_END;
         default: ;
      endcase
      if (c >= ieval_pkg::CH_ZERO && c <= ieval_pkg::CH_NINE) begin
         if (err == ieval_pkg::ST_OK) begin
            accum      = accum * 10 + VW'(c - ieval_pkg::CH_ZERO);
            accum_live = 1;
         end
         return;
      end
      if (code == ieval_pkg::OP_NONE) begin
         flag(ieval_pkg::ST_BADEX);
         return;
      end
      if (err == ieval_pkg::ST_OK) apply_operator(code);
      if (code != ieval_pkg::OP_END) return;
      o.value  = (err == ieval_pkg::ST_OK && num_count >= 1) ? num_stack[0] : '0;
      o.status = err;
      expected_results.push_back(o);
      clear_evaluator();
   endfunction

   // stimulus helpers
   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) char_queue.push_back(s[i]);
   endtask

   function automatic string random_number();
      string s;
      int    n;
      s = "";
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
         s = {s, string'(8'(ieval_pkg::CH_ZERO + $urandom_range(0, 9)))};
      return s;
   endfunction

   function automatic string random_term(int depth);
      if (depth > 0 && $urandom_range(0, 3) == 0)
         return {"(", random_expr(depth - 1), ")"};
      return random_number();
   endfunction

   function automatic string random_expr(int depth);
      string ops, s;
      int    n;
      ops = "+-*/";
      n   = $urandom_range(0, 5);
      s   = random_term(depth);
      for (int i = 0; i < n; i++)
         s = {s, string'(ops[$urandom_range(0, 3)]), random_term(depth)};
      return s;
   endfunction

   // driver: bursts and gaps
   int burst_left = 0;
   int gap_left   = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.ch    <= 8'h00;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) predict_char(req_chan.ch);
         if (gap_left > 0) begin
            gap_left       <= gap_left - 1;
            req_chan.valid <= 1'b0;
         end else if (char_queue.size() > 0) begin
            req_chan.valid <= 1'b1;
            req_chan.ch    <= char_queue.pop_front();
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 30);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // monitor with its own stall pattern
   int cycle_count = 0;
   always @(posedge clock) begin
      outcome_type o;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               $error("result with none expected: value %0d status %0d",
                      rsp_chan.value, rsp_chan.status);
               failures++;
            end else begin
               o = expected_results.pop_front();
               if (rsp_chan.value !== o.value) begin
                  $error("value: expected %0d, got %0d", o.value, rsp_chan.value);
                  failures++;
               end
               if (rsp_chan.status !== o.status) begin
                  $error("status: expected %0d, got %0d", o.status, rsp_chan.status);
                  failures++;
               end
            end
         end
         rsp_chan.ready <= (cycle_count[9:8] == 2'b11) ? 1'b1 :
                           ($urandom_range(0, 2) != 0);
      end
   end

   // watchdog on accepted items
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          reset || stimulus_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("infix_expression_evaluator_test NOT OK");
         $finish;
      end
   end

   initial begin
      string noise;
      string tail_ops;
      int    idle;
      clear_evaluator();
      tail_ops = "+-*/()";
      req_chan.valid = 1'b0;
      req_chan.ch    = 8'h00;
      rsp_chan.ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: operators, precedence, parentheses and each error
      send_text("1+2*3-4/2=");
      send_text("(1+2)*(7-3)/2=");
      send_text("2147483647+1=");
      send_text("0-2147483648/1=");
      send_text("0-2147483648/(0-1)=");
      send_text("7/(0-2)=");
      send_text("5/0=");
      send_text("99999999999*3=");
      send_text("=");
      send_text("3(4)=");
      send_text("(1+2=");
      send_text("1+2)=");
      send_text("1++2=");
      send_text("1 +2=");
      send_text("((((((((((((((((1))))))))))))))))=");
      send_text("1+(2+(3+(4+(5+(6+(7+(8+(9+(1+(2+(3+(4+(5+(6+(7+8)))))))))))))))=");
      send_text("1*2=");
      // every byte value at least once, including top bits
      for (int i = 0; i < 256; i++) char_queue.push_back(8'(i));
      send_text("=");

      // random: mostly well formed expressions, some noise
      while (char_queue.size() < 1300) begin
         case ($urandom_range(0, 9))
            0: begin
               noise = "";
               for (int i = $urandom_range(1, 6); i > 0; i--)
                  noise = {noise, string'(8'($urandom_range(0, 255)))};
               send_text({random_expr(2), noise, "="});
            end
            1: send_text({random_expr(1), string'(tail_ops[$urandom_range(0, 5)]), "="});
            default: send_text({random_expr(3), "="});
         endcase
      end

      wait (char_queue.size() == 0 && !req_chan.valid);
      stimulus_done = 1;
      idle = 0;
      while (expected_results.size() > 0 && idle < 100000) begin
         @(posedge clock);
         idle++;
      end
      repeat (200) @(posedge clock);
      if (failures == 0 && expected_results.size() == 0)
         $display("infix_expression_evaluator_test OK");
      else
         $display("infix_expression_evaluator_test NOT OK");
      $finish;
   end

endmodule
